>>> design/pcbe_pkg.sv
// ----------------------------------------------------------------------------
// pcbe_pkg
// Shared types and constants of the prefix-compressed block encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcbe_pkg;

   // item kinds carried on the request tuser
   typedef enum logic [1:0] {
      OP_KEY   = 2'd0,
      OP_VALUE = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   localparam int OPCODE_W    = 2;
   localparam int BYTE_W      = 8;
   localparam int KEY_LEN_W   = 9;
   localparam int VAL_LEN_W   = 32;
   localparam int OFFSET_W    = 32;

   localparam int REQ_TDATA_W = 56;   // 49 field bits, padded to 7 bytes
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;

   localparam int                CSR_W         = 11;
   localparam logic [CSR_W-1:0]  RESTART_RESET = 11'd16;
   localparam logic [CSR_W-1:0]  ENTRY_CNT_MAX = 11'd2047;

endpackage

`default_nettype wire

>>> design/prefix_compressed_block_encoder.sv
// ----------------------------------------------------------------------------
// prefix_compressed_block_encoder
// Prefix-compressing encoder for sorted key-value entries, one byte a transfer.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                         | tuser / tlast
//  --------+-----+--------------------------------------------+----------------------
//  csr_    | in  | csr_data: restart_interval[10:0]           | -
//  req_    | in  | data_byte[7:0] key_length[16:8]            | tuser: opcode[1:0]
//          |     | val_len[48:17], zero pad [55:49]           | tlast: field_last
//  rsp_    | out | out_byte[7:0] entry_offset[39:8]           | tuser: is_header[0]
//          |     |                                            |  entry_start[1]
//          |     |                                            |  restart_point[2]
//          |     |                                            | tlast: run_last
//
//  Cycles: while rsp_tready is high, one request transfer a cycle for value bytes,
//  shared key bytes and key bytes after the header. A key byte that closes the shared
//  prefix produces its varint header plus the byte itself, 4 to 10 result transfers
//  (3 to 9 when the whole key is shared and only the header leaves), paced by the
//  serial varint emitter at one output byte a cycle; requests stall while it drains.
//  A request passes the stage 1, job and output registers before its first result.
//  Reset is synchronous; the previous-key memory needs no clearing pass, as
//  an entry is only compared below the stored previous key length.
//  A low rsp_tready holds the output register and back-pressure moves up
//  through the job and compare stages to req_tready.
//
`default_nettype none

module prefix_compressed_block_encoder #(
   parameter int MAX_KEY_LENGTH = 256
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // configuration write: restart_interval[10:0]
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [pcbe_pkg::CSR_W-1:0]            csr_data,
   // request: tdata = data_byte, key_length, val_len; tuser = opcode
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [pcbe_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire  [pcbe_pkg::OPCODE_W-1:0]         req_tuser,
   input  wire                                   req_tlast,
   // response: tdata = out_byte, entry_offset
   //           tuser = is_header, entry_start, restart_point
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [pcbe_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [pcbe_pkg::RSP_TUSER_W-1:0]      rsp_tuser,
   output logic                                  rsp_tlast
);

   // index reaches MAX_KEY_LENGTH itself when it saturates
   localparam int IDX_W  = $clog2(MAX_KEY_LENGTH + 1);
   localparam int ADDR_W = (MAX_KEY_LENGTH > 1) ? $clog2(MAX_KEY_LENGTH) : 1;
   localparam int CMP_W  = (IDX_W > pcbe_pkg::KEY_LEN_W) ? IDX_W : pcbe_pkg::KEY_LEN_W;
   localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_KEY_LENGTH);

   localparam int KW = pcbe_pkg::KEY_LEN_W;
   localparam int VW = pcbe_pkg::VAL_LEN_W;
   localparam int BW = pcbe_pkg::BYTE_W;

   // which header field the emitter is working through
   typedef enum logic [1:0] {
      SEL_SHARED,
      SEL_UNSHARED,
      SEL_VALUE
   } field_sel_type;

   // ------------------------------------------------------------------------
   // request unpacking
   // ------------------------------------------------------------------------
   pcbe_pkg::opcode_type in_op;
   logic [BW-1:0]        in_byte;
   logic [KW-1:0]        in_klen;
   logic [VW-1:0]        in_vlen;
   logic                 req_xfer;

   assign in_op    = pcbe_pkg::opcode_type'(req_tuser);
   assign in_byte  = req_tdata[7:0];
   assign in_klen  = req_tdata[16:8];
   assign in_vlen  = req_tdata[48:17];
   assign req_xfer = req_tvalid && req_tready;

   // ------------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------------
   logic [pcbe_pkg::CSR_W-1:0] interval_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= pcbe_pkg::RESTART_RESET;
      end else if (csr_valid && csr_ready) begin
         interval_ff <= csr_data;
      end
   end

   // ------------------------------------------------------------------------
   // stage 0: byte index, previous-key memory read and write
   // ------------------------------------------------------------------------
   logic [IDX_W-1:0]  byte_index_ff;
   logic [IDX_W-1:0]  byte_index_in;
   logic [IDX_W-1:0]  next_index;
   logic              idx_in_range;
   logic [ADDR_W-1:0] key_addr;

   assign idx_in_range = byte_index_ff < IDX_LIMIT;
   assign next_index   = idx_in_range ? byte_index_ff + IDX_W'(1) : byte_index_ff;
   assign key_addr     = idx_in_range ? byte_index_ff[ADDR_W-1:0] : '0;

   always_comb begin
      byte_index_in = byte_index_ff;
      if (req_xfer) begin
         unique case (in_op)
            pcbe_pkg::OP_KEY:   byte_index_in = req_tlast ? '0 : next_index;
            pcbe_pkg::OP_CLEAR: byte_index_in = '0;
            default:            byte_index_in = byte_index_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
      end else begin
         byte_index_ff <= byte_index_in;
      end
   end

   // read returns the old byte when the same entry is overwritten
   logic [BW-1:0] key_mem [MAX_KEY_LENGTH];
   logic [BW-1:0] prev_byte_ff;

   always_ff @(posedge clock) begin
      if (req_xfer && in_op == pcbe_pkg::OP_KEY) begin
         prev_byte_ff <= key_mem[key_addr];
         if (idx_in_range) begin
            key_mem[key_addr] <= in_byte;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: compare and entry state
   // ------------------------------------------------------------------------
   logic                 s1_valid_ff;
   pcbe_pkg::opcode_type s1_op_ff;
   logic [BW-1:0]        s1_byte_ff;
   logic [KW-1:0]        s1_klen_ff;
   logic [VW-1:0]        s1_vlen_ff;
   logic                 s1_last_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic [IDX_W-1:0]     s1_nidx_ff;

   logic [IDX_W-1:0]            prev_len_ff, prev_len_in;
   logic [KW-1:0]               prefix_ff, prefix_in;
   logic                        hdr_done_ff, hdr_done_in;
   logic [pcbe_pkg::CSR_W-1:0]  entries_ff, entries_in;
   logic                        blk_empty_ff, blk_empty_in;

   logic          job_hdr, job_tail, job_clear, job_rst, s1_job;
   logic [KW-1:0] job_shared, job_unshared;
   logic          j_ready, s1_go;

   always_comb begin
      logic                       restart;
      logic [pcbe_pkg::CSR_W-1:0] ent_base;
      logic [KW-1:0]              pc_base;
      logic                       match;
      restart      = 1'b0;
      ent_base     = entries_ff;
      pc_base      = prefix_ff;
      match        = 1'b0;
      prev_len_in  = prev_len_ff;
      prefix_in    = prefix_ff;
      hdr_done_in  = hdr_done_ff;
      entries_in   = entries_ff;
      blk_empty_in = blk_empty_ff;
      job_hdr      = 1'b0;
      job_tail     = 1'b0;
      job_clear    = 1'b0;
      job_rst      = 1'b0;
      job_shared   = '0;
      if (s1_valid_ff) begin
         unique case (s1_op_ff)
            pcbe_pkg::OP_KEY: begin
               job_tail = 1'b1;
               if (!hdr_done_ff) begin
                  // first byte of an entry: decide on a restart point
                  if (s1_idx_ff == '0) begin
                     restart      = blk_empty_ff || (entries_ff >= interval_ff);
                     ent_base     = restart ? '0 : entries_ff;
                     entries_in   = (ent_base < pcbe_pkg::ENTRY_CNT_MAX) ?
                                    ent_base + 11'd1 : ent_base;
                     blk_empty_in = 1'b0;
                     pc_base      = '0;
                  end
                  prefix_in = pc_base;
                  match = !restart && (s1_idx_ff < prev_len_ff) &&
                          (CMP_W'(s1_idx_ff) < CMP_W'(s1_klen_ff)) &&
                          (s1_idx_ff < IDX_LIMIT) && (prev_byte_ff == s1_byte_ff);
                  if (match) begin
                     prefix_in  = pc_base + KW'(1);
                     job_tail   = 1'b0;
                     job_hdr    = s1_last_ff;
                     job_shared = pc_base + KW'(1);
                  end else begin
                     job_hdr     = 1'b1;
                     job_shared  = restart ? '0 : pc_base;
                     job_rst     = restart;
                     hdr_done_in = 1'b1;
                  end
               end
               if (s1_last_ff) begin
                  prev_len_in = s1_nidx_ff;
                  prefix_in   = '0;
                  hdr_done_in = 1'b0;
               end
            end
            pcbe_pkg::OP_VALUE: begin
               job_tail = 1'b1;
            end
            pcbe_pkg::OP_CLEAR: begin
               job_clear    = 1'b1;
               prev_len_in  = '0;
               prefix_in    = '0;
               hdr_done_in  = 1'b0;
               entries_in   = '0;
               blk_empty_in = 1'b1;
            end
            default: begin
               // unused opcode: drop without results
            end
         endcase
      end
   end

   assign job_unshared = (s1_klen_ff > job_shared) ? s1_klen_ff - job_shared : '0;
   assign s1_job       = job_hdr || job_tail || job_clear;
   assign s1_go        = s1_valid_ff && (!s1_job || j_ready);
   assign req_tready   = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         prev_len_ff  <= '0;
         prefix_ff    <= '0;
         hdr_done_ff  <= 1'b0;
         entries_ff   <= '0;
         blk_empty_ff <= 1'b1;
      end else begin
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            prev_len_ff  <= prev_len_in;
            prefix_ff    <= prefix_in;
            hdr_done_ff  <= hdr_done_in;
            entries_ff   <= entries_in;
            blk_empty_ff <= blk_empty_in;
         end
      end
   end

   // hold the item payload beside the memory read
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff   <= in_op;
         s1_byte_ff <= in_byte;
         s1_klen_ff <= in_klen;
         s1_vlen_ff <= in_vlen;
         s1_last_ff <= req_tlast;
         s1_idx_ff  <= byte_index_ff;
         s1_nidx_ff <= next_index;
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: job register and serial varint emitter
   // ------------------------------------------------------------------------
   logic          j_valid_ff, j_clear_ff, j_hdr_ff, j_first_ff, j_rst_ff, j_tail_ff;
   field_sel_type j_sel_ff;
   logic [VW-1:0] j_cur_ff;
   logic [KW-1:0] j_unsh_ff;
   logic [VW-1:0] j_vlen_ff;
   logic [BW-1:0] j_byte_ff;

   logic          out_free, j_step, j_finish;
   logic          more;
   logic [BW-1:0] gen_byte;
   logic          gen_hdr, gen_first, gen_rst, gen_final;

   assign out_free = !rsp_tvalid || rsp_tready;
   assign more     = |j_cur_ff[VW-1:7];

   always_comb begin
      if (j_hdr_ff) begin
         gen_byte  = {more, j_cur_ff[6:0]};
         gen_hdr   = 1'b1;
         gen_first = j_first_ff;
         gen_rst   = j_first_ff && j_rst_ff;
         gen_final = !more && (j_sel_ff == SEL_VALUE) && !j_tail_ff;
      end else begin
         gen_byte  = j_byte_ff;
         gen_hdr   = 1'b0;
         gen_first = 1'b0;
         gen_rst   = 1'b0;
         gen_final = 1'b1;
      end
   end

   assign j_step   = j_valid_ff && !j_clear_ff && out_free;
   assign j_finish = j_valid_ff && (j_clear_ff || (out_free && gen_final));
   assign j_ready  = !j_valid_ff || j_finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         j_valid_ff <= 1'b0;
      end else if (s1_go && s1_job) begin
         j_valid_ff <= 1'b1;
      end else if (j_finish) begin
         j_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_job) begin
         j_clear_ff <= job_clear;
         j_hdr_ff   <= job_hdr;
         j_first_ff <= 1'b1;
         j_rst_ff   <= job_rst;
         j_tail_ff  <= job_tail;
         j_sel_ff   <= SEL_SHARED;
         j_cur_ff   <= VW'(job_shared);
         j_unsh_ff  <= job_unshared;
         j_vlen_ff  <= s1_vlen_ff;
         j_byte_ff  <= s1_byte_ff;
      end else if (j_step) begin
         if (j_hdr_ff) begin
            j_first_ff <= 1'b0;
            if (more) begin
               j_cur_ff <= j_cur_ff >> 7;
            end else begin
               unique case (j_sel_ff)
                  SEL_SHARED: begin
                     j_sel_ff <= SEL_UNSHARED;
                     j_cur_ff <= VW'(j_unsh_ff);
                  end
                  SEL_UNSHARED: begin
                     j_sel_ff <= SEL_VALUE;
                     j_cur_ff <= j_vlen_ff;
                  end
                  SEL_VALUE: begin
                     j_hdr_ff <= 1'b0;
                  end
                  default: begin
                     j_hdr_ff <= 1'b0;
                  end
               endcase
            end
         end else begin
            j_tail_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // output register and block offset
   // ------------------------------------------------------------------------
   logic                          rsp_valid_ff;
   logic [BW-1:0]                 rsp_byte_ff;
   logic [pcbe_pkg::OFFSET_W-1:0] rsp_off_ff;
   logic                          rsp_hdr_ff, rsp_first_ff, rsp_rst_ff, rsp_last_ff;
   logic [pcbe_pkg::OFFSET_W-1:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         offset_ff    <= '0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= j_step;
         end
         if (j_valid_ff && j_clear_ff) begin
            offset_ff <= '0;
         end else if (j_step) begin
            offset_ff <= offset_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (j_step) begin
         rsp_byte_ff  <= gen_byte;
         rsp_off_ff   <= offset_ff;
         rsp_hdr_ff   <= gen_hdr;
         rsp_first_ff <= gen_first;
         rsp_rst_ff   <= gen_rst;
         rsp_last_ff  <= gen_final;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_off_ff, rsp_byte_ff};
   assign rsp_tuser  = {rsp_rst_ff, rsp_first_ff, rsp_hdr_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

>>> design/pcbe_checker.sv
// ----------------------------------------------------------------------------
// pcbe_checker
// Port-level assertions for the prefix-compressed block encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbe_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 rsp_tvalid,
   input wire                                 rsp_tready,
   input wire [pcbe_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input wire [pcbe_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   input wire                                 rsp_tlast
);

   logic                          rsp_xfer;
   logic [pcbe_pkg::OFFSET_W-1:0] last_off_ff;
   logic                          last_tlast_ff;

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // track the previous result transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         last_off_ff   <= '1;
         last_tlast_ff <= 1'b1;
      end else if (rsp_xfer) begin
         last_off_ff   <= rsp_tdata[39:8];
         last_tlast_ff <= rsp_tlast;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_offset_step: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> (rsp_tdata[39:8] == last_off_ff + 32'd1) || (rsp_tdata[39:8] == '0))
      else $error("block offset did not advance by one");

   a_entry_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_tuser[1] |-> last_tlast_ff && rsp_tuser[0])
      else $error("entry start inside another item's results");

   a_plain_byte_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && !rsp_tuser[1] && !rsp_tuser[2])
      else $error("plain byte is not the final result of its item");

   a_varint_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && rsp_tdata[7] |-> !rsp_tlast)
      else $error("varint continuation byte marked as final");

endmodule

bind prefix_compressed_block_encoder pcbe_checker u_pcbe_checker (.*);

`default_nettype wire
